@@ sv/tcp_segment_reorder_core_assert.svh @@
// Assertion macros used by the checker file of the reorder core.
`ifndef TCP_SEGMENT_REORDER_CORE_ASSERT_SVH
`define TCP_SEGMENT_REORDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TSR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tsr_pkg.sv @@
// Types, constants and compare functions of the TCP segment reorder core.
package tsr_pkg;

   localparam int DEPTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [2:0] DISP_RELEASED = 3'd0;
   localparam logic [2:0] DISP_SIDE     = 3'd1;
   localparam logic [2:0] DISP_DISCARD  = 3'd2;
   localparam logic [2:0] DISP_FLUSHED  = 3'd3;
   localparam logic [2:0] DISP_OVERFLOW = 3'd4;

   // One held segment
   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] ack;
      logic [11:0] handle;
      logic [15:0] len;
      logic        syn_fin;
   } tsr_entry_type;

   // Store access controls
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } tsr_mem_ctl_type;

   // One result without its run marker
   typedef struct packed {
      logic [11:0] handle;
      logic [31:0] seq;
      logic [2:0]  disp;
   } tsr_result_type;

   // Wrapping serial compare: a < b
   function automatic logic serial_lt(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] diff;
      diff = a - b;
      return diff[31];
   endfunction

   // Sort order: held entry goes ahead of the new segment
   function automatic logic sorts_before(input tsr_entry_type h, input tsr_entry_type n);
      return serial_lt(h.seq, n.seq) || ((h.seq == n.seq) && serial_lt(h.ack, n.ack));
   endfunction

endpackage

@@ sv/tsr_store.sv @@
// Segment store: one write port, one registered read port.
module tsr_store
   import tsr_pkg::*;
(
   input  logic            clock,
   input  tsr_mem_ctl_type ctl,
   input  tsr_entry_type   wr_data,
   output tsr_entry_type   rd_data
);

   tsr_entry_type store_ff [DEPTH];
   tsr_entry_type rd_data_ff;

   // Write, then registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= store_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/tcp_segment_reorder_core.sv @@
// Reorder core: takes one segment descriptor per transfer and emits held
// segments in sequence order. Held segments sit in a 32-entry circular store
// with one read and one write port; the controller handles one segment at a
// time. The time from its transfer to the next grows with each held entry it
// moves past on insertion, each released segment and each flushed segment,
// and with each flush pass, on SYN or on an overlapping head. All of this is
// set by the single store read port and its registered read, and result-side
// stalls add to it. Results leave through an output register backed by one
// pending slot, so the last result of a run is marked once the run is known to
// be over. No clearing pass after reset.
module tcp_segment_reorder_core
   import tsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_packet_handle,
   input  logic [31:0] req_seq_number,
   input  logic [31:0] req_ack_number,
   input  logic [15:0] req_payload_length,
   input  logic        req_syn_flag,
   input  logic        req_fin_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_out_handle,
   output logic [31:0] rsp_out_seq,
   output logic [2:0]  rsp_disposition,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_side_output_enabled
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_FL_RD, ST_FL_EMIT, ST_INS_RD, ST_INS_CHK,
      ST_RL_RD, ST_RL_CHK, ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      exp_ff, exp_in;
   logic [31:0]      lastrel_ff, lastrel_in;
   logic             side_ff, side_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             flnext_ff, flnext_in;
   tsr_entry_type    cur_ff, cur_in;
   logic             pend_valid_ff, pend_valid_in;
   tsr_result_type   pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tsr_result_type   rsp_ff, rsp_in;
   logic             rsp_last_ff, rsp_last_in;

   tsr_mem_ctl_type  mem_ctl;
   tsr_entry_type    mem_wr;
   tsr_entry_type    mem_rd;

   logic             emit_req;
   tsr_result_type   emit_data;
   logic             fin_req;
   logic             out_free;
   logic             can_emit;
   logic [IDX_W-1:0] idx_lo;
   logic [IDX_W-1:0] idx_prev;
   logic [CNT_W-1:0] idx_dec;

   tsr_store u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_data (mem_wr),
      .rd_data (mem_rd)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign can_emit  = !pend_valid_ff || out_free;
   assign idx_lo    = idx_ff[IDX_W-1:0];
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign idx_prev  = idx_dec[IDX_W-1:0];
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   // Sequencer: store walks and result requests
   always_comb begin
      state_in   = state_ff;
      exp_in     = exp_ff;
      lastrel_in = lastrel_ff;
      side_in    = side_ff;
      cnt_in     = cnt_ff;
      head_in    = head_ff;
      idx_in     = idx_ff;
      flnext_in  = flnext_ff;
      cur_in     = cur_ff;
      mem_ctl    = '0;
      mem_wr     = cur_ff;
      emit_req   = 1'b0;
      emit_data  = '0;
      fin_req    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               side_in = csr_side_output_enabled;
            end
            if (req_valid) begin
               cur_in.seq     = req_seq_number;
               cur_in.ack     = req_ack_number;
               cur_in.handle  = req_packet_handle;
               cur_in.len     = req_payload_length;
               cur_in.syn_fin = req_syn_flag | req_fin_flag;
               if (req_syn_flag) begin
                  exp_in    = req_seq_number;
                  idx_in    = '0;
                  flnext_in = 1'b0;
                  state_in  = ST_FL_RD;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_FL_RD: begin
            if (idx_ff == cnt_ff) begin
               cnt_in   = '0;
               state_in = flnext_ff ? ST_FINISH : ST_DECIDE;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = head_ff + idx_lo;
               state_in        = ST_FL_EMIT;
            end
         end
         ST_FL_EMIT: begin
            emit_req  = 1'b1;
            emit_data = '{handle: mem_rd.handle, seq: mem_rd.seq, disp: DISP_FLUSHED};
            if (can_emit) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_FL_RD;
            end
         end
         ST_DECIDE: begin
            if (serial_lt(cur_ff.seq, exp_ff)) begin
               emit_req  = 1'b1;
               emit_data = '{handle: cur_ff.handle, seq: cur_ff.seq,
                             disp: (side_ff && !serial_lt(cur_ff.seq, lastrel_ff))
                                   ? DISP_SIDE : DISP_DISCARD};
               if (can_emit) begin
                  state_in = ST_FINISH;
               end
            end else if (cnt_ff == CNT_W'(DEPTH)) begin
               emit_req  = 1'b1;
               emit_data = '{handle: cur_ff.handle, seq: cur_ff.seq, disp: DISP_OVERFLOW};
               if (can_emit) begin
                  state_in = ST_FINISH;
               end
            end else begin
               idx_in   = cnt_ff;
               state_in = ST_INS_RD;
            end
         end
         // Insertion walks from the tail, shifting up entries that do not sort ahead of it
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_addr = head_ff;
               cnt_in          = cnt_ff + CNT_W'(1);
               state_in        = ST_RL_RD;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = head_ff + idx_prev;
               state_in        = ST_INS_CHK;
            end
         end
         ST_INS_CHK: begin
            mem_ctl.wr_en   = 1'b1;
            mem_ctl.wr_addr = head_ff + idx_lo;
            if (sorts_before(mem_rd, cur_ff)) begin
               cnt_in   = cnt_ff + CNT_W'(1);
               state_in = ST_RL_RD;
            end else begin
               mem_wr   = mem_rd;
               idx_in   = idx_dec;
               state_in = ST_INS_RD;
            end
         end
         // Release from the head while in order
         ST_RL_RD: begin
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               mem_ctl.rd_en   = 1'b1;
               mem_ctl.rd_addr = head_ff;
               state_in        = ST_RL_CHK;
            end
         end
         ST_RL_CHK: begin
            if (serial_lt(mem_rd.seq, exp_ff)) begin
               idx_in    = '0;
               flnext_in = 1'b1;
               state_in  = ST_FL_RD;
            end else if (mem_rd.seq != exp_ff) begin
               state_in = ST_FINISH;
            end else begin
               emit_req  = 1'b1;
               emit_data = '{handle: mem_rd.handle, seq: mem_rd.seq, disp: DISP_RELEASED};
               if (can_emit) begin
                  exp_in     = mem_rd.seq + 32'(mem_rd.len) + 32'(mem_rd.syn_fin);
                  lastrel_in = mem_rd.seq;
                  head_in    = head_ff + IDX_W'(1);
                  cnt_in     = cnt_ff - CNT_W'(1);
                  state_in   = ST_RL_RD;
               end
            end
         end
         ST_FINISH: begin
            fin_req = 1'b1;
            if (!pend_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result path: pending slot feeds the output register
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit_req && can_emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = pend_ff;
            rsp_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = emit_data;
      end else if (fin_req && pend_valid_ff && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = pend_ff;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         exp_ff        <= '0;
         lastrel_ff    <= '0;
         side_ff       <= 1'b0;
         cnt_ff        <= '0;
         head_ff       <= '0;
         idx_ff        <= '0;
         flnext_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         exp_ff        <= exp_in;
         lastrel_ff    <= lastrel_in;
         side_ff       <= side_in;
         cnt_ff        <= cnt_in;
         head_ff       <= head_in;
         idx_ff        <= idx_in;
         flnext_ff     <= flnext_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_handle  = rsp_ff.handle;
   assign rsp_out_seq     = rsp_ff.seq;
   assign rsp_disposition = rsp_ff.disp;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

@@ sv/tsr_checker.sv @@
// Port-level checker for the reorder core, bound to the top level.
`include "tcp_segment_reorder_core_assert.svh"

module tsr_checker
   import tsr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_seq,
   input logic [2:0]  rsp_disposition,
   input logic        csr_ready
);

   // Held result stays put while stalled
   `TSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_seq), "stalled result changed")

   // Only defined codes leave the block
   `TSR_ASSERT_NOW(a_disp_code, clock, reset, rsp_valid, rsp_disposition <= DISP_OVERFLOW, "bad disposition code")

   // Config and segment intake open together
   `TSR_ASSERT_NOW(a_idle_ports, clock, reset, 1'b1, csr_ready == req_ready, "intake ready mismatch")

   // A segment transfer closes intake for the next cycle
   `TSR_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready, !req_ready, "intake open while busy")

endmodule

bind tcp_segment_reorder_core tsr_checker u_tsr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_seq     (rsp_out_seq),
   .rsp_disposition (rsp_disposition),
   .csr_ready       (csr_ready)
);
